// ===== hw/rtl/vna_pkg.sv =====
// -----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared types and fixed constants for the controller, the datapath and the top.
// -----------------------------------------------------------------------------
package vna_pkg;

   // Fixed field widths.
   localparam int ACT_BITS   = 2;
   localparam int IDX_BITS   = 10;
   localparam int POS_BITS   = 16;
   localparam int NRM_BITS   = 16;

   // Accumulator width and normalization constants.
   localparam int SUM_BITS   = 48;
   localparam int NORM_HI    = 30;
   localparam int NORM_LO    = 29;
   localparam int MAG_BITS   = 30;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SS_BITS    = 62;
   localparam int ROOT_BITS  = 31;
   localparam int RT_BITS    = 63;
   localparam int UNIT_SHIFT = 14;
   localparam int UNIT       = 16384;
   localparam int QUOT_BITS  = 15;
   localparam int DVW_BITS   = 46;

   // Sequencer step counts. The square root walks bit pairs 62 down to 0.
   localparam int CNT_BITS   = 5;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 15;
   localparam int SQ_STEPS   = 4;
   localparam int LAST_AXIS  = 2;

   typedef enum logic [ACT_BITS-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_TRI   = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_LOAD,
      ST_PA, ST_PB, ST_PC, ST_PLATCH, ST_DIFF, ST_MUL, ST_SUB,
      ST_SRD, ST_SWR,
      ST_QRD, ST_QLATCH, ST_NORM, ST_SQ, ST_ROOT, ST_DINIT, ST_DIV,
      ST_DONE, ST_ZERO
   } state_type;

   // Commands from the controller to the datapath and the output stage.
   typedef struct packed {
      logic       cap;
      logic       pos_wr;
      logic [1:0] rd_sel;
      logic       p_latch;
      logic [1:0] lat_sel;
      logic       diff_en;
      logic       mul_en;
      logic       sub_en;
      logic [1:0] k;
      logic       sum_wr;
      logic       q_latch;
      logic       shr;
      logic       shl;
      logic       sq_init;
      logic       sq_step;
      logic       root_init;
      logic       root_step;
      logic       div_init;
      logic       div_step;
      logic       div_last;
      logic       out_load;
      logic       out_degen;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACT_BITS-1:0] act;
      logic                a_ok;
      logic                tri_ok;
      logic                mx_zero;
      logic                mx_big;
      logic                mx_small;
   } stat_type;

endpackage

// ===== hw/rtl/vna_ctrl.sv =====
// -----------------------------------------------------------------------------
// Vertex normal accumulator controller
// State machine that sequences loads, triangle adds and normalized queries.
// -----------------------------------------------------------------------------
module vna_ctrl import vna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     out_free,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [1:0]            k_ff, k_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.k     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.cap   = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            k_in = '0;
            case (action_type'(stat.act))
               ACT_LOAD:  state_in = stat.a_ok ? ST_LOAD : ST_IDLE;
               ACT_TRI:   state_in = stat.tri_ok ? ST_PA : ST_IDLE;
               ACT_QUERY: state_in = stat.a_ok ? ST_QRD : ST_ZERO;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_LOAD: begin
            cmd.pos_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         // Fetch the three corner positions.
         ST_PA: begin
            cmd.rd_sel = 2'd0;
            state_in   = ST_PB;
         end
         ST_PB: begin
            cmd.rd_sel  = 2'd1;
            cmd.p_latch = 1'b1;
            cmd.lat_sel = 2'd0;
            state_in    = ST_PC;
         end
         ST_PC: begin
            cmd.rd_sel  = 2'd2;
            cmd.p_latch = 1'b1;
            cmd.lat_sel = 2'd1;
            state_in    = ST_PLATCH;
         end
         ST_PLATCH: begin
            cmd.p_latch = 1'b1;
            cmd.lat_sel = 2'd2;
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            k_in        = '0;
            state_in    = ST_MUL;
         end
         // One cross product axis per multiply and subtract pair.
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub_en = 1'b1;
            if (k_ff == 2'(LAST_AXIS)) begin
               k_in     = '0;
               state_in = ST_SRD;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         // Read-modify-write of each corner accumulator in order a, b, c.
         ST_SRD: begin
            state_in = ST_SWR;
         end
         ST_SWR: begin
            cmd.sum_wr = 1'b1;
            if (k_ff == 2'(LAST_AXIS)) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SRD;
            end
         end
         ST_QRD: begin
            state_in = ST_QLATCH;
         end
         ST_QLATCH: begin
            cmd.q_latch = 1'b1;
            state_in    = ST_NORM;
         end
         // Shift the magnitudes one bit a cycle into the working range.
         ST_NORM: begin
            if (stat.mx_zero) begin
               state_in = ST_ZERO;
            end else if (stat.mx_big) begin
               cmd.shr = 1'b1;
            end else if (stat.mx_small) begin
               cmd.shl = 1'b1;
            end else begin
               cmd.sq_init = 1'b1;
               cnt_in      = '0;
               state_in    = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.k       = cnt_ff[1:0];
            cmd.sq_step = 1'b1;
            if (cnt_ff == CNT_BITS'(SQ_STEPS - 1)) begin
               cmd.root_init = 1'b1;
               cnt_in        = '0;
               state_in      = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               k_in     = '0;
               state_in = ST_DINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               cmd.div_last = 1'b1;
               cnt_in       = '0;
               if (k_ff == 2'(LAST_AXIS)) begin
                  k_in     = '0;
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_DINIT;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_degen = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/vna_dp.sv =====
// -----------------------------------------------------------------------------
// Vertex normal accumulator datapath
// Position and sum memories, cross product, accumulation and normalization.
// -----------------------------------------------------------------------------
module vna_dp import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                       clock,
   input  cmd_type                    cmd,
   input  logic [ACT_BITS-1:0]        req_action,
   input  logic [IDX_BITS-1:0]        req_vertex_a,
   input  logic [IDX_BITS-1:0]        req_vertex_b,
   input  logic [IDX_BITS-1:0]        req_vertex_c,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   output stat_type                   stat,
   output logic signed [NRM_BITS-1:0] nrm_x,
   output logic signed [NRM_BITS-1:0] nrm_y,
   output logic signed [NRM_BITS-1:0] nrm_z
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = COORD_BITS;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int NW = PW + 1;
   localparam int TW = ((SUM_BITS > NW) ? SUM_BITS : NW) + 1;
   localparam logic signed [TW-1:0] SAT_HI = {{(TW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

   logic [ACT_BITS-1:0]            act_ff;
   logic [IDX_BITS-1:0]            idx_ff [3];
   logic [CW-1:0]                  crd_ff [3];
   logic [2:0]                     idx_ok;
   logic [AW-1:0]                  addr [3];
   logic [AW-1:0]                  pos_ra, sum_a;

   logic [3*CW-1:0]                pos_mem [MAX_VERTICES];
   logic [3*CW-1:0]                pos_rd_ff;
   logic [3*SUM_BITS-1:0]          sum_mem [MAX_VERTICES];
   logic [3*SUM_BITS-1:0]          sum_rd_ff;
   logic [3*SUM_BITS-1:0]          sum_wd;

   logic signed [CW-1:0]           pa_ff [3], pb_ff [3], pc_ff [3];
   logic signed [DW-1:0]           u_ff [3], v_ff [3];
   logic signed [DW-1:0]           m1a, m1b, m2a, m2b;
   logic signed [PW-1:0]           pr1_ff, pr2_ff;
   logic signed [NW-1:0]           n_ff [3];

   logic signed [SUM_BITS-1:0]     old_s [3];
   logic signed [TW-1:0]           t_s [3];
   logic signed [SUM_BITS-1:0]     new_s [3];

   logic [SUM_BITS-1:0]            mag_c [3];
   logic [SUM_BITS-1:0]            mag_ff [3];
   logic [2:0]                     neg_ff;
   logic [SUM_BITS-1:0]            mx_c, mx_ff;

   logic [MAG_BITS-1:0]            sq_sel;
   logic [SQ_BITS-1:0]             sq_ff;
   logic [SS_BITS-1:0]             ss_ff;
   logic [RT_BITS-1:0]             res_ff, bit_ff, trial;
   logic                           root_ge;

   logic [ROOT_BITS-1:0]           len;
   logic [MAG_BITS-1:0]            dv_mag;
   logic                           dv_neg;
   logic [DVW_BITS-1:0]            rem_ff, dv_ff;
   logic [QUOT_BITS-1:0]           q_ff, q_nx, q_cap;
   logic                           div_ge;
   logic signed [NRM_BITS-1:0]     nrm_ff [3];

   // Capture the accepted word.
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         act_ff    <= req_action;
         idx_ff[0] <= req_vertex_a;
         idx_ff[1] <= req_vertex_b;
         idx_ff[2] <= req_vertex_c;
         crd_ff[0] <= CW'($unsigned(req_pos_x));
         crd_ff[1] <= CW'($unsigned(req_pos_y));
         crd_ff[2] <= CW'($unsigned(req_pos_z));
      end
   end

   // Index range checks and memory addresses.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         idx_ok[i] = (32'(idx_ff[i]) < 32'(MAX_VERTICES));
         addr[i]   = AW'(idx_ff[i]);
      end
      pos_ra = addr[2];
      sum_a  = addr[2];
      for (int i = 0; i < 2; i++) begin
         if (cmd.rd_sel == 2'(i)) begin
            pos_ra = addr[i];
         end
         if (cmd.k == 2'(i)) begin
            sum_a = addr[i];
         end
      end
   end

   assign stat.act      = act_ff;
   assign stat.a_ok     = idx_ok[0];
   assign stat.tri_ok   = &idx_ok;
   assign stat.mx_zero  = (mx_ff == '0);
   assign stat.mx_big   = |mx_ff[SUM_BITS-1:NORM_HI];
   assign stat.mx_small = ~|mx_ff[SUM_BITS-1:NORM_LO];

   // Position memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.pos_wr) begin
         pos_mem[addr[0]] <= {crd_ff[2], crd_ff[1], crd_ff[0]};
      end
      pos_rd_ff <= pos_mem[pos_ra];
   end

   // Corner position registers.
   always_ff @(posedge clock) begin
      if (cmd.p_latch) begin
         for (int c = 0; c < 3; c++) begin
            case (cmd.lat_sel)
               2'd0:    pa_ff[c] <= $signed(pos_rd_ff[c*CW +: CW]);
               2'd1:    pb_ff[c] <= $signed(pos_rd_ff[c*CW +: CW]);
               default: pc_ff[c] <= $signed(pos_rd_ff[c*CW +: CW]);
            endcase
         end
      end
   end

   // Edge vectors from corner a. The cross product is the same from every corner.
   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         for (int c = 0; c < 3; c++) begin
            u_ff[c] <= DW'(pb_ff[c]) - DW'(pa_ff[c]);
            v_ff[c] <= DW'(pc_ff[c]) - DW'(pa_ff[c]);
         end
      end
   end

   // Operand selection for one cross product axis.
   always_comb begin
      case (cmd.k)
         2'd0: begin
            m1a = u_ff[1]; m1b = v_ff[2]; m2a = u_ff[2]; m2b = v_ff[1];
         end
         2'd1: begin
            m1a = u_ff[2]; m1b = v_ff[0]; m2a = u_ff[0]; m2b = v_ff[2];
         end
         default: begin
            m1a = u_ff[0]; m1b = v_ff[1]; m2a = u_ff[1]; m2b = v_ff[0];
         end
      endcase
   end

   // Products are registered, then subtracted in the following cycle.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         pr1_ff <= m1a * m1b;
         pr2_ff <= m2a * m2b;
      end
      if (cmd.sub_en) begin
         for (int c = 0; c < 3; c++) begin
            if (cmd.k == 2'(c)) begin
               n_ff[c] <= NW'(pr1_ff) - NW'(pr2_ff);
            end
         end
      end
   end

   // Saturating add of the face normal into the corner accumulator.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         old_s[c] = $signed(sum_rd_ff[c*SUM_BITS +: SUM_BITS]);
         t_s[c]   = TW'(old_s[c]) + TW'(n_ff[c]);
         if (t_s[c] > SAT_HI) begin
            new_s[c] = SAT_HI[SUM_BITS-1:0];
         end else if (t_s[c] < SAT_LO) begin
            new_s[c] = SAT_LO[SUM_BITS-1:0];
         end else begin
            new_s[c] = t_s[c][SUM_BITS-1:0];
         end
      end
      sum_wd = {new_s[2], new_s[1], new_s[0]};
   end

   // Sum memory: a load clears the entry, a corner write stores the new sum.
   always_ff @(posedge clock) begin
      if (cmd.pos_wr) begin
         sum_mem[addr[0]] <= '0;
      end else if (cmd.sum_wr) begin
         sum_mem[sum_a] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_a];
   end

   // Magnitudes and their maximum for a query.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_c[c] = old_s[c][SUM_BITS-1] ? (~old_s[c] + 1'b1) : old_s[c];
      end
      mx_c = mag_c[0];
      if (mag_c[1] > mx_c) begin
         mx_c = mag_c[1];
      end
      if (mag_c[2] > mx_c) begin
         mx_c = mag_c[2];
      end
   end

   // Magnitude registers with one-bit normalizing shifts.
   always_ff @(posedge clock) begin
      if (cmd.q_latch) begin
         for (int c = 0; c < 3; c++) begin
            mag_ff[c] <= mag_c[c];
            neg_ff[c] <= old_s[c][SUM_BITS-1];
         end
         mx_ff <= mx_c;
      end else if (cmd.shr) begin
         for (int c = 0; c < 3; c++) begin
            mag_ff[c] <= mag_ff[c] >> 1;
         end
         mx_ff <= mx_ff >> 1;
      end else if (cmd.shl) begin
         for (int c = 0; c < 3; c++) begin
            mag_ff[c] <= mag_ff[c] << 1;
         end
         mx_ff <= mx_ff << 1;
      end
   end

   // Component selection for squaring and division.
   always_comb begin
      sq_sel = '0;
      dv_mag = '0;
      dv_neg = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (cmd.k == 2'(c)) begin
            sq_sel = mag_ff[c][MAG_BITS-1:0];
            dv_mag = mag_ff[c][MAG_BITS-1:0];
            dv_neg = neg_ff[c];
         end
      end
   end

   // Sum of squares, then a bit-pair square root on the same register.
   assign trial   = res_ff + bit_ff;
   assign root_ge = ({1'b0, ss_ff} >= trial);
   assign len     = res_ff[ROOT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         sq_ff <= '0;
         ss_ff <= '0;
      end else if (cmd.sq_step) begin
         sq_ff <= sq_sel * sq_sel;
         ss_ff <= ss_ff + SS_BITS'(sq_ff);
      end else if (cmd.root_step && root_ge) begin
         ss_ff <= SS_BITS'({1'b0, ss_ff} - trial);
      end
      if (cmd.root_init) begin
         res_ff <= '0;
         bit_ff <= RT_BITS'(1) << SS_BITS;
      end else if (cmd.root_step) begin
         res_ff <= root_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
         bit_ff <= bit_ff >> 2;
      end
   end

   // Restoring division, one quotient bit a cycle, rounded to nearest.
   assign div_ge = (rem_ff >= dv_ff);
   assign q_nx   = {q_ff[QUOT_BITS-2:0], div_ge};
   assign q_cap  = (q_nx > QUOT_BITS'(UNIT)) ? QUOT_BITS'(UNIT) : q_nx;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= DVW_BITS'({dv_mag, {UNIT_SHIFT{1'b0}}}) + DVW_BITS'(len >> 1);
         dv_ff  <= DVW_BITS'({len, {UNIT_SHIFT{1'b0}}});
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? (rem_ff - dv_ff) : rem_ff;
         dv_ff  <= dv_ff >> 1;
         q_ff   <= q_nx;
      end
      if (cmd.div_last) begin
         for (int c = 0; c < 3; c++) begin
            if (cmd.k == 2'(c)) begin
               nrm_ff[c] <= dv_neg ? -NRM_BITS'(q_cap) : NRM_BITS'(q_cap);
            end
         end
      end
   end

   assign nrm_x = nrm_ff[0];
   assign nrm_y = nrm_ff[1];
   assign nrm_z = nrm_ff[2];

endmodule

// ===== hw/rtl/vertex_normal_accumulator.sv =====
// -----------------------------------------------------------------------------
// Vertex normal accumulator
// Area-weighted smooth vertex normals with a registered result word.
// -----------------------------------------------------------------------------
// Words are handled one at a time by a single controller. A load writes the
// position memory and clears the sum entry; a triangle does three position reads,
// one cross product over three multiply and subtract steps and three accumulator
// read-modify-writes on the sum memory. A query does up to 29 one-bit normalizing
// shifts, 4 square steps, 32 square root steps and one divider run per axis.
// A query of a zero sum or of an out-of-range vertex skips to a degenerate result.
// A query also waits while the output register still holds an earlier word that
// has not been taken. A query result waits in the output register, so the next
// word is accepted while it is still pending.
module vertex_normal_accumulator import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACT_BITS-1:0]        req_action,
   input  logic [IDX_BITS-1:0]        req_vertex_a,
   input  logic [IDX_BITS-1:0]        req_vertex_b,
   input  logic [IDX_BITS-1:0]        req_vertex_c,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   input  logic signed [POS_BITS-1:0] req_pos_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [NRM_BITS-1:0] rsp_normal_x,
   output logic signed [NRM_BITS-1:0] rsp_normal_y,
   output logic signed [NRM_BITS-1:0] rsp_normal_z,
   output logic                       rsp_degenerate
);

   cmd_type                    cmd;
   stat_type                   stat;
   logic                       out_free;
   logic signed [NRM_BITS-1:0] nrm_x, nrm_y, nrm_z;
   logic                       rsp_valid_ff;
   logic signed [NRM_BITS-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                       rsp_degen_ff;

   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   vna_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .req_action   (req_action),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .req_vertex_c (req_vertex_c),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .stat         (stat),
      .nrm_x        (nrm_x),
      .nrm_y        (nrm_y),
      .nrm_z        (nrm_z)
   );

   // The output register frees up when empty or when its word is taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload; a degenerate sum or an out-of-range query vertex gives a zero normal.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_degen_ff <= cmd.out_degen;
         rsp_x_ff     <= cmd.out_degen ? '0 : nrm_x;
         rsp_y_ff     <= cmd.out_degen ? '0 : nrm_y;
         rsp_z_ff     <= cmd.out_degen ? '0 : nrm_z;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_x_ff;
   assign rsp_normal_y   = rsp_y_ff;
   assign rsp_normal_z   = rsp_z_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule
